@@ src/hog_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog_pkg
// shared types, register codes and cordic constants of the cell histogram
// ----------------------------------------------------------------------------
package hog_pkg;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int MAG_W     = 17;
  localparam int ANG_W     = 17;
  localparam int CFG_DW    = 6;
  localparam int CFG_IW    = 2;
  localparam int WEIGHT_W  = 32;
  localparam int BINNUM_W  = 5;
  localparam int CORDIC_STEPS = 14;

  localparam logic [CFG_IW-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BINS     = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_UNSIGNED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
  } hog_pixel_t;

  typedef struct packed {
    logic [BINNUM_W-1:0] bin_number;
    logic [WEIGHT_W-1:0] bin_weight;
    logic [WEIGHT_W-1:0] weight_total;
    logic                final_bin;
  } hog_result_t;

  typedef struct packed {
    logic                    done;
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] angle;
  } hog_grad_t;

  function automatic logic signed [17:0] cordic_ang(input logic [3:0] i);
    logic signed [17:0] a;
    case (i)
      4'd0:    a = 18'sd8192;
      4'd1:    a = 18'sd4836;
      4'd2:    a = 18'sd2555;
      4'd3:    a = 18'sd1297;
      4'd4:    a = 18'sd651;
      4'd5:    a = 18'sd326;
      4'd6:    a = 18'sd163;
      4'd7:    a = 18'sd81;
      4'd8:    a = 18'sd41;
      4'd9:    a = 18'sd20;
      4'd10:   a = 18'sd10;
      4'd11:   a = 18'sd5;
      4'd12:   a = 18'sd3;
      4'd13:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ src/hog_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog_stream_if
// valid/ready channel carrying one request payload
// ----------------------------------------------------------------------------
interface hog_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/hog_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/hog_grad_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog_grad_unit
// iterative magnitude (bitwise square root) and angle (cordic) of a gradient
// ----------------------------------------------------------------------------
module hog_grad_unit import hog_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [8:0] gx,
  input  logic signed [8:0] gy,
  output hog_grad_t         res
);

  localparam int RW = 21;
  localparam int XW = 28;

  logic                 busy_r;
  logic [4:0]           it_r;
  logic [33:0]          n_r;
  logic [RW-1:0]        rem_r, root_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [17:0]   z_r, base_r;
  logic                 spec_r;
  logic signed [17:0]   spec_ang_r;
  hog_grad_t            res_r;

  logic signed [17:0]   gxx, gyy, sq;
  logic signed [XW-1:0] gx_w, gy_w, dx, dy;
  logic [RW-1:0]        rem_sh, trial;
  logic signed [17:0]   ang_sum;
  logic signed [17:0]   ang_clamp;

  always_comb begin
    gxx     = 18'(gx) * 18'(gx);
    gyy     = 18'(gy) * 18'(gy);
    sq      = gxx + gyy;
    gx_w    = XW'(gx);
    gy_w    = XW'(gy);
    rem_sh  = {rem_r[RW-3:0], n_r[33:32]};
    trial   = {root_r[RW-3:0], 2'b01};
    dx      = cy_r >>> it_r[3:0];
    dy      = cx_r >>> it_r[3:0];
    ang_sum = base_r + z_r;
    if (ang_sum > 18'sd32768) begin
      ang_clamp = 18'sd32768;
    end else if (ang_sum < -18'sd32768) begin
      ang_clamp = -18'sd32768;
    end else begin
      ang_clamp = ang_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      it_r     <= '0;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
        n_r    <= {1'b0, sq[16:0], 16'd0};
        rem_r  <= '0;
        root_r <= '0;
        z_r    <= '0;
        if (gx < 0) begin
          cx_r   <= (-gx_w) <<< 16;
          cy_r   <= (-gy_w) <<< 16;
          base_r <= (gy > 0) ? 18'sd32768 : -18'sd32768;
        end else begin
          cx_r   <= gx_w <<< 16;
          cy_r   <= gy_w <<< 16;
          base_r <= '0;
        end
        if (gy == 0) begin
          spec_r     <= 1'b1;
          spec_ang_r <= (gx < 0) ? 18'sd32768 : 18'sd0;
        end else if (gx == 0) begin
          spec_r     <= 1'b1;
          spec_ang_r <= (gy > 0) ? 18'sd16384 : -18'sd16384;
        end else begin
          spec_r     <= 1'b0;
          spec_ang_r <= '0;
        end
      end else if (busy_r) begin
        if (it_r < 5'd17) begin
          n_r <= {n_r[31:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          if (it_r < 5'(CORDIC_STEPS)) begin
            if (cy_r >= 0) begin
              cx_r <= cx_r + dx;
              cy_r <= cy_r - dy;
              z_r  <= z_r + cordic_ang(it_r[3:0]);
            end else begin
              cx_r <= cx_r - dx;
              cy_r <= cy_r + dy;
              z_r  <= z_r - cordic_ang(it_r[3:0]);
            end
          end
          it_r <= it_r + 5'd1;
        end else begin
          busy_r      <= 1'b0;
          res_r.done  <= 1'b1;
          res_r.mag   <= root_r[MAG_W-1:0] + MAG_W'(rem_r > root_r);
          res_r.angle <= spec_r ? ANG_W'(spec_ang_r) : ANG_W'(ang_clamp);
        end
      end
    end
  end

  assign res = res_r;

endmodule

@@ src/hog_cell_orientation_histogram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog_cell_orientation_histogram
// orientation histogram of a grayscale cell, accumulated across images
// ----------------------------------------------------------------------------
// usage
//   in_px carries one pixel per request in raster order; one pixel is taken
//   per cycle while loading. the request that completes width*height pixels
//   starts the gradient pass, during which in_px.ready is low
//   gradient pass: per pixel, four reads of the single read port of the image
//   ram, then the 17 step square root that runs beside the 14 step cordic in
//   the shared gradient unit
//   out_res then gives bin_count results, each by bin ram read, capture and
//   hand over, the last one with final_bin set
//   a stalled receiver holds the current result; loading resumes after the
//   last result is taken. cfg_we writes register cfg_index with cfg_data at
//   once; the user writes only while idle, the block does not enforce it
//   reset clears the registers to their defaults, the bins and the total
//   (bin valid flags) and the pixel count; the image ram needs no clearing
// ----------------------------------------------------------------------------
module hog_cell_orientation_histogram import hog_pkg::*; #(
  parameter int MAX_SIDE = 16,
  parameter int MAX_BINS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  hog_stream_if.sink        in_px,
  hog_stream_if.source      out_res
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NBW   = $clog2(MAX_BINS + 1);
  localparam int WHW   = 2 * SW;
  localparam int CW    = (WHW > CNT_W) ? WHW : CNT_W;
  localparam int PW    = ANG_W + BW;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_CALC  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_LOOK  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_EREAD = 9'b001000000,
    S_ECAP  = 9'b010000000,
    S_EHOLD = 9'b100000000
  } state_t;

  state_t        state_r;
  logic [4:0]    width_r, height_r;
  logic [5:0]    bins_r;
  logic          unsigned_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0] addr_r, base_r;
  logic [XW-1:0] x_r, y_r;
  logic [2:0]    ph_r;
  logic [PIX_W-1:0] pl_r, pr_r, pu_r;
  logic [PW-1:0] prod_r;
  logic [BW-1:0] bin_r, k_r;
  logic [MAX_BINS-1:0] valid_r;
  logic [WEIGHT_W-1:0] total_r;
  logic          out_valid_r;
  hog_result_t   out_r;

  logic [SW-1:0]  side_w, side_h;
  logic [NBW-1:0] nb;
  logic [BW-1:0]  nbm1;
  logic [CW-1:0]  wh;
  logic [CNT_W-1:0] cnt_inc;
  logic [XW-1:0]  xl, xr;
  logic [AW-1:0]  up_base, dn_base, fetch_addr;
  logic [PIX_W-1:0] img_rd;
  logic [WEIGHT_W-1:0] bin_rd, bin_old, bin_new, total_new;
  logic [WEIGHT_W:0]   bin_sum, total_sum;
  logic signed [8:0] gx, gy;
  logic          grad_start;
  hog_grad_t     grad;
  logic signed [ANG_W:0] a_ext;
  logic [ANG_W-1:0] u;
  logic [PW:0]   qsum, q;
  logic [BW-1:0] bin_sel, bin_raddr;
  logic          px_acc, last_x, last_y;

  always_comb begin
    if (int'(width_r) < 2) side_w = SW'(2);
    else if (int'(width_r) > MAX_SIDE) side_w = SW'(MAX_SIDE);
    else side_w = SW'(width_r);
    if (int'(height_r) < 2) side_h = SW'(2);
    else if (int'(height_r) > MAX_SIDE) side_h = SW'(MAX_SIDE);
    else side_h = SW'(height_r);
    if (bins_r == 6'd0) nb = NBW'(1);
    else if (int'(bins_r) > MAX_BINS) nb = NBW'(MAX_BINS);
    else nb = NBW'(bins_r);
    nbm1    = BW'(nb - NBW'(1));
    wh      = CW'(side_w) * CW'(side_h);
    cnt_inc = cnt_r + CNT_W'(1);
    px_acc  = in_px.valid && in_px.ready;

    last_x  = (x_r == XW'(side_w - SW'(1)));
    last_y  = (y_r == XW'(side_h - SW'(1)));
    xl      = (x_r == '0) ? XW'(1) : x_r - XW'(1);
    xr      = last_x ? x_r - XW'(1) : x_r + XW'(1);
    up_base = (y_r == '0) ? base_r + AW'(side_w) : base_r - AW'(side_w);
    dn_base = last_y ? base_r - AW'(side_w) : base_r + AW'(side_w);
    case (ph_r)
      3'd0:    fetch_addr = base_r + AW'(xl);
      3'd1:    fetch_addr = base_r + AW'(xr);
      3'd2:    fetch_addr = up_base + AW'(x_r);
      default: fetch_addr = dn_base + AW'(x_r);
    endcase

    gx = signed'({1'b0, pr_r}) - signed'({1'b0, pl_r});
    gy = signed'({1'b0, img_rd}) - signed'({1'b0, pu_r});
    grad_start = (state_r == S_FETCH) && (ph_r == 3'd4);

    a_ext = (ANG_W+1)'(grad.angle);
    if (unsigned_r && grad.angle >= 0) begin
      u = ANG_W'(a_ext);
    end else begin
      u = ANG_W'(a_ext + (ANG_W+1)'(32768));
    end
    if (unsigned_r) begin
      qsum = (PW+1)'(prod_r) + (PW+1)'(16384);
      q    = qsum >> 15;
    end else begin
      qsum = (PW+1)'(prod_r) + (PW+1)'(32768);
      q    = qsum >> 16;
    end
    bin_sel   = (q > (PW+1)'(nbm1)) ? nbm1 : BW'(q);
    bin_raddr = (state_r == S_LOOK) ? bin_sel : k_r;

    bin_old   = valid_r[bin_r] ? bin_rd : '0;
    bin_sum   = (WEIGHT_W+1)'(bin_old) + (WEIGHT_W+1)'(grad.mag);
    bin_new   = bin_sum[WEIGHT_W] ? '1 : bin_sum[WEIGHT_W-1:0];
    total_sum = (WEIGHT_W+1)'(total_r) + (WEIGHT_W+1)'(grad.mag);
    total_new = total_sum[WEIGHT_W] ? '1 : total_sum[WEIGHT_W-1:0];
  end

  hog_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_img_ram (
    .clk   (clk),
    .we    (px_acc),
    .waddr (addr_r),
    .wdata (in_px.data.pixel),
    .raddr (fetch_addr),
    .rdata (img_rd)
  );

  hog_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (bin_r),
    .wdata (bin_new),
    .raddr (bin_raddr),
    .rdata (bin_rd)
  );

  hog_grad_unit u_grad (
    .clk   (clk),
    .rst_n (rst_n),
    .start (grad_start),
    .gx    (gx),
    .gy    (gy),
    .res   (grad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      width_r     <= 5'd8;
      height_r    <= 5'd8;
      bins_r      <= 6'd9;
      unsigned_r  <= 1'b1;
      cnt_r       <= '0;
      addr_r      <= '0;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:    width_r    <= cfg_data[4:0];
          CFG_HEIGHT:   height_r   <= cfg_data[4:0];
          CFG_BINS:     bins_r     <= cfg_data;
          CFG_UNSIGNED: unsigned_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_LOAD: begin
          if (px_acc) begin
            if (CW'(cnt_inc) >= wh) begin
              cnt_r   <= '0;
              addr_r  <= '0;
              x_r     <= '0;
              y_r     <= '0;
              base_r  <= '0;
              ph_r    <= '0;
              state_r <= S_FETCH;
            end else begin
              cnt_r  <= cnt_inc;
              addr_r <= (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
            end
          end
        end
        S_FETCH: begin
          ph_r <= ph_r + 3'd1;
          case (ph_r)
            3'd1:    pl_r <= img_rd;
            3'd2:    pr_r <= img_rd;
            3'd3:    pu_r <= img_rd;
            default: ;
          endcase
          if (ph_r == 3'd4) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (grad.done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(u) * PW'(nbm1);
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          bin_r   <= bin_sel;
          state_r <= S_ACC;
        end
        S_ACC: begin
          valid_r[bin_r] <= 1'b1;
          total_r        <= total_new;
          ph_r           <= '0;
          if (last_x) begin
            x_r    <= '0;
            y_r    <= y_r + XW'(1);
            base_r <= base_r + AW'(side_w);
            if (last_y) begin
              k_r     <= '0;
              state_r <= S_EREAD;
            end else begin
              state_r <= S_FETCH;
            end
          end else begin
            x_r     <= x_r + XW'(1);
            state_r <= S_FETCH;
          end
        end
        S_EREAD: begin
          state_r <= S_ECAP;
        end
        S_ECAP: begin
          out_r.bin_number   <= BINNUM_W'(k_r);
          out_r.bin_weight   <= valid_r[k_r] ? bin_rd : '0;
          out_r.weight_total <= total_r;
          out_r.final_bin    <= (k_r == nbm1);
          out_valid_r        <= 1'b1;
          state_r            <= S_EHOLD;
        end
        S_EHOLD: begin
          if (out_res.ready) begin
            out_valid_r <= 1'b0;
            if (out_r.final_bin) begin
              state_r <= S_LOAD;
            end else begin
              k_r     <= k_r + BW'(1);
              state_r <= S_EREAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_px.ready   = (state_r == S_LOAD);
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_r;

endmodule
